>>> hdl/vap_pkg.sv
// Package for the vertex attribute layout packer.
// Field widths, the component size table, size/alignment rules and the
// request/response types of the serial remainder unit. No dependencies.
package vap_pkg;

    localparam int OFS_W         = 12;
    localparam int ALIGN_W       = 7;
    localparam int BYTES_W       = 7;
    localparam int TYPE_W        = 3;
    localparam int LEN_W         = 5;
    localparam int INDEX_W       = 4;
    localparam int MAX_ATTRS_DEF = 16;

    localparam logic [TYPE_W-1:0] TYPE_PACKED10 = 3'd7;

    typedef struct packed {
        logic               start;
        logic [OFS_W-1:0]   dividend;
        logic [ALIGN_W-1:0] divisor;
    } rem_req_t;

    typedef struct packed {
        logic               done;
        logic [ALIGN_W-1:0] rem;
    } rem_rsp_t;

    // component size in bytes: 1,1,2,2,4,4,4,4
    function automatic logic [2:0] unit_bytes(input logic [TYPE_W-1:0] ctype);
        logic [2:0] c;
        case (ctype)
            3'd0, 3'd1: c = 3'd1;
            3'd2, 3'd3: c = 3'd2;
            default:    c = 3'd4;
        endcase
        return c;
    endfunction

    function automatic logic [BYTES_W-1:0] calc_bytes(input logic [TYPE_W-1:0] ctype,
                                                     input logic [LEN_W-1:0]  clen);
        logic [7:0] prod;
        prod = {3'b000, clen} * {5'b00000, unit_bytes(ctype)};
        if (ctype == TYPE_PACKED10)
            return BYTES_W'(4);
        return prod[BYTES_W-1:0];
    endfunction

    function automatic logic [ALIGN_W-1:0] calc_align(input logic [TYPE_W-1:0]  ctype,
                                                     input logic [LEN_W-1:0]   clen,
                                                     input logic [ALIGN_W-1:0] min_stride);
        logic [2:0]         c;
        logic [ALIGN_W-1:0] cw;
        c  = unit_bytes(ctype);
        cw = ALIGN_W'(c);
        if (ctype == TYPE_PACKED10)
            return ALIGN_W'(4);
        if (clen == LEN_W'(3) && c <= 3'd2)
            return ALIGN_W'({c, 2'b00});
        return (min_stride > cw) ? min_stride : cw;
    endfunction

endpackage

>>> hdl/vap_rem_serial.sv
// Bit-serial restoring remainder: offset mod alignment, one dividend bit per cycle.
// Depends on vap_pkg (widths, rem_req_t, rem_rsp_t).
module vap_rem_serial
(
    input  logic              clk,
    input  logic              rst_n,
    input  vap_pkg::rem_req_t req,
    output vap_pkg::rem_rsp_t rsp
);

    localparam int STEP_W = $clog2(vap_pkg::OFS_W);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(vap_pkg::OFS_W - 1);

    logic                        busy_reg, busy_next;
    logic [STEP_W-1:0]           cnt_reg, cnt_next;
    logic [vap_pkg::OFS_W-1:0]   shift_reg, shift_next;
    logic [vap_pkg::ALIGN_W-1:0] rem_reg, rem_next;
    logic [vap_pkg::ALIGN_W-1:0] div_reg, div_next;

    logic [vap_pkg::ALIGN_W:0]   trial;
    logic [vap_pkg::ALIGN_W:0]   trial_sub;
    logic                        ge;
    logic [vap_pkg::ALIGN_W-1:0] rem_step;

    // trial = 2*rem + next bit, stays below twice the divisor
    assign trial     = {rem_reg, shift_reg[vap_pkg::OFS_W-1]};
    assign trial_sub = trial - {1'b0, div_reg};
    assign ge        = (trial >= {1'b0, div_reg});
    assign rem_step  = ge ? trial_sub[vap_pkg::ALIGN_W-1:0] : trial[vap_pkg::ALIGN_W-1:0];

    assign rsp.done = busy_reg && (cnt_reg == LAST_STEP);
    assign rsp.rem  = rem_step;

    always_comb
    begin
        busy_next  = busy_reg;
        cnt_next   = cnt_reg;
        shift_next = shift_reg;
        rem_next   = rem_reg;
        div_next   = div_reg;
        if (req.start)
        begin
            busy_next  = 1'b1;
            cnt_next   = '0;
            shift_next = req.dividend;
            rem_next   = '0;
            div_next   = req.divisor;
        end
        else if (busy_reg)
        begin
            shift_next = {shift_reg[vap_pkg::OFS_W-2:0], 1'b0};
            rem_next   = rem_step;
            cnt_next   = cnt_reg + STEP_W'(1);
            if (cnt_reg == LAST_STEP)
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
        rem_reg   <= rem_next;
        div_reg   <= div_next;
    end

    a_rem_below_div: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.done |-> (rsp.rem < div_reg))
        else $error("remainder not below divisor");

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |=> busy_reg && (cnt_reg == '0))
        else $error("start did not launch a pass");

    a_busy_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && !rsp.done && !req.start) |=> busy_reg && (cnt_reg == $past(cnt_reg) + 1'b1))
        else $error("pass ended early");

endmodule

>>> hdl/vertex_attribute_layout_packer.sv
// Top level of the vertex attribute layout packer: control FSM, format state,
// output register. Depends on vap_pkg and vap_rem_serial.
//
//  channel  | handshake              | payload
//  ---------+------------------------+--------------------------------------------
//  in       | in_valid / in_ready    | elem_type, elem_count, last_attr
//  out      | out_valid / out_ready  | attr_index, attr_offset, attr_bytes,
//           |                        | vertex_stride, overflow
//  cfg      | cfg_we (no wait)       | cfg_wdata -> min_stride
//
// Sequence: an attribute that opens a format or overflows needs no offset pass;
//   any other takes one 12-step pass of the serial remainder unit. A last
//   attribute adds a 12-step pass for the stride, also when it opens the
//   format or overflows.
// One attribute in flight at a time; in_ready rises again once the result is in
//   the output register, so the next transfer can come while it waits.
// Output stalls hold the FSM in its final state; nothing is dropped.
// Reset: empty format, min_stride 1, no result pending. No clearing pass.
module vertex_attribute_layout_packer
#(
    parameter int MAX_ATTRS = vap_pkg::MAX_ATTRS_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [vap_pkg::ALIGN_W-1:0] cfg_wdata,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [vap_pkg::TYPE_W-1:0]  elem_type,
    input  logic [vap_pkg::LEN_W-1:0]   elem_count,
    input  logic                        last_attr,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [vap_pkg::INDEX_W-1:0] attr_index,
    output logic [vap_pkg::OFS_W-1:0]   attr_offset,
    output logic [vap_pkg::BYTES_W-1:0] attr_bytes,
    output logic [vap_pkg::OFS_W-1:0]   vertex_stride,
    output logic                        overflow
);

    localparam int CNT_W = $clog2(MAX_ATTRS + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_ATTRS);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,  // waiting for an attribute
        ST_OFS  = 4'b0010,  // remainder pass for attribute offset
        ST_STR  = 4'b0100,  // remainder pass for vertex stride
        ST_DONE = 4'b1000   // result ready for the output register
    } state_t;

    state_t                      state_reg, state_next;
    logic [vap_pkg::ALIGN_W-1:0] min_stride_reg, min_stride_next;
    logic [vap_pkg::OFS_W-1:0]   run_reg, run_next;
    logic [vap_pkg::ALIGN_W-1:0] first_align_reg, first_align_next;
    logic [CNT_W-1:0]            count_reg, count_next;

    // current attribute
    logic [vap_pkg::ALIGN_W-1:0] align_reg, align_next;
    logic [vap_pkg::BYTES_W-1:0] bytes_reg, bytes_next;
    logic [vap_pkg::INDEX_W-1:0] index_reg, index_next;
    logic                        last_reg, last_next;
    logic                        ovf_reg, ovf_next;
    logic [vap_pkg::OFS_W-1:0]   off_reg, off_next;
    logic [vap_pkg::OFS_W-1:0]   stride_reg, stride_next;

    // output register
    logic                        out_valid_reg, out_valid_next;
    logic [vap_pkg::INDEX_W-1:0] o_index_reg, o_index_next;
    logic [vap_pkg::OFS_W-1:0]   o_off_reg, o_off_next;
    logic [vap_pkg::BYTES_W-1:0] o_bytes_reg, o_bytes_next;
    logic [vap_pkg::OFS_W-1:0]   o_stride_reg, o_stride_next;
    logic                        o_ovf_reg, o_ovf_next;

    vap_pkg::rem_req_t rem_req;
    vap_pkg::rem_rsp_t rem_rsp;

    logic [vap_pkg::ALIGN_W-1:0] in_align;
    logic [vap_pkg::BYTES_W-1:0] in_bytes;
    logic                        in_full;
    logic [vap_pkg::ALIGN_W-1:0] pad_div;
    logic [vap_pkg::ALIGN_W-1:0] pad_gap;
    logic [vap_pkg::OFS_W-1:0]   padded;
    logic [vap_pkg::OFS_W-1:0]   placed_end;
    logic                        out_load;

    vap_rem_serial u_rem
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (rem_req),
        .rsp   (rem_rsp)
    );

    assign in_align = vap_pkg::calc_align(elem_type, elem_count, min_stride_reg);
    assign in_bytes = vap_pkg::calc_bytes(elem_type, elem_count);
    assign in_full  = (count_reg >= CNT_FULL);

    // round run_reg up to the divisor of the pass in progress (mod 4096)
    assign pad_div    = (state_reg == ST_OFS) ? align_reg : first_align_reg;
    assign pad_gap    = pad_div - rem_rsp.rem;
    assign padded     = (rem_rsp.rem == '0) ? run_reg
                                            : run_reg + vap_pkg::OFS_W'(pad_gap);
    assign placed_end = padded + vap_pkg::OFS_W'(bytes_reg);

    assign in_ready = (state_reg == ST_IDLE);
    assign out_load = (state_reg == ST_DONE) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next       = state_reg;
        min_stride_next  = cfg_we ? cfg_wdata : min_stride_reg;
        run_next         = run_reg;
        first_align_next = first_align_reg;
        count_next       = count_reg;
        align_next       = align_reg;
        bytes_next       = bytes_reg;
        index_next       = index_reg;
        last_next        = last_reg;
        ovf_next         = ovf_reg;
        off_next         = off_reg;
        stride_next      = stride_reg;
        rem_req          = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    last_next   = last_attr;
                    align_next  = in_align;
                    stride_next = '0;
                    off_next    = '0;
                    if (in_full)
                    begin
                        // table full: attribute dropped, format may still close
                        ovf_next   = 1'b1;
                        bytes_next = '0;
                        index_next = '0;
                    end
                    else
                    begin
                        ovf_next   = 1'b0;
                        bytes_next = in_bytes;
                        index_next = vap_pkg::INDEX_W'(count_reg);
                        count_next = count_reg + CNT_W'(1);
                    end

                    if (!in_full && count_reg != '0)
                    begin
                        rem_req.start    = 1'b1;
                        rem_req.dividend = run_reg;
                        rem_req.divisor  = in_align;
                        state_next       = ST_OFS;
                    end
                    else
                    begin
                        if (!in_full)
                        begin
                            // first attribute sits at zero, sets stride alignment
                            first_align_next = in_align;
                            run_next         = vap_pkg::OFS_W'(in_bytes);
                        end
                        if (last_attr)
                        begin
                            rem_req.start    = 1'b1;
                            rem_req.dividend = run_next;
                            rem_req.divisor  = first_align_next;
                            state_next       = ST_STR;
                        end
                        else
                            state_next = ST_DONE;
                    end
                end
            end

            ST_OFS:
            begin
                if (rem_rsp.done)
                begin
                    off_next = padded;
                    run_next = placed_end;
                    if (last_reg)
                    begin
                        rem_req.start    = 1'b1;
                        rem_req.dividend = placed_end;
                        rem_req.divisor  = first_align_reg;
                        state_next       = ST_STR;
                    end
                    else
                        state_next = ST_DONE;
                end
            end

            ST_STR:
            begin
                if (rem_rsp.done)
                begin
                    stride_next      = padded;
                    run_next         = '0;
                    first_align_next = vap_pkg::ALIGN_W'(1);
                    count_next       = '0;
                    state_next       = ST_DONE;
                end
            end

            ST_DONE:
            begin
                if (out_load)
                    state_next = ST_IDLE;
            end

            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        o_index_next   = o_index_reg;
        o_off_next     = o_off_reg;
        o_bytes_next   = o_bytes_reg;
        o_stride_next  = o_stride_reg;
        o_ovf_next     = o_ovf_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
            o_index_next   = index_reg;
            o_off_next     = off_reg;
            o_bytes_next   = bytes_reg;
            o_stride_next  = stride_reg;
            o_ovf_next     = ovf_reg;
        end
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            min_stride_reg  <= vap_pkg::ALIGN_W'(1);
            run_reg         <= '0;
            first_align_reg <= vap_pkg::ALIGN_W'(1);
            count_reg       <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            min_stride_reg  <= min_stride_next;
            run_reg         <= run_next;
            first_align_reg <= first_align_next;
            count_reg       <= count_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        align_reg    <= align_next;
        bytes_reg    <= bytes_next;
        index_reg    <= index_next;
        last_reg     <= last_next;
        ovf_reg      <= ovf_next;
        off_reg      <= off_next;
        stride_reg   <= stride_next;
        o_index_reg  <= o_index_next;
        o_off_reg    <= o_off_next;
        o_bytes_reg  <= o_bytes_next;
        o_stride_reg <= o_stride_next;
        o_ovf_reg    <= o_ovf_next;
    end

    assign out_valid     = out_valid_reg;
    assign attr_index    = o_index_reg;
    assign attr_offset   = o_off_reg;
    assign attr_bytes    = o_bytes_reg;
    assign vertex_stride = o_stride_reg;
    assign overflow      = o_ovf_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_FULL)
        else $error("attribute count past capacity");

    a_ovf_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && o_ovf_reg) |->
            (o_index_reg == '0) && (o_off_reg == '0) && (o_bytes_reg == '0))
        else $error("overflow result carries data");

    a_done_in_pass: assert property (@(posedge clk) disable iff (!rst_n)
        rem_rsp.done |-> (state_reg == ST_OFS) || (state_reg == ST_STR))
        else $error("remainder result outside a pass");

    a_align_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        first_align_reg != '0)
        else $error("zero stride alignment");

endmodule
